// File: design/page_table_map_and_walk_top_defines.svh
// ----------------------------------------------------------------------------
// Page table map and walk: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAP_AND_WALK_TOP_DEFINES_SVH
`define PAGE_TABLE_MAP_AND_WALK_TOP_DEFINES_SVH

// same-cycle implication
`define PTMW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptmw: same-cycle check failed");

// next-cycle implication
`define PTMW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptmw: next-cycle check failed");

`endif

// File: design/ptmw_pkg.sv
// ----------------------------------------------------------------------------
// Page table map and walk: package
// Codes, entry bits and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptmw_pkg;

   localparam int POOL_TABLES_DEFAULT = 64;

   localparam logic [1:0] REQ_MAP       = 2'd0;
   localparam logic [1:0] REQ_TRANSLATE = 2'd1;
   localparam logic [1:0] REQ_CLONE     = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

   localparam logic CSR_POOL_BASE  = 1'b0;
   localparam logic CSR_POOL_PAGES = 1'b1;

   localparam logic [63:0] ENT_PRESENT = 64'h1;
   localparam logic [63:0] ENT_RW      = 64'h2;
   localparam logic [63:0] ENT_USER    = 64'h4;
   localparam logic [63:0] ENT_PS      = 64'h80;

   localparam logic [48:0] SIZE_4K = 49'h1000;
   localparam logic [48:0] SIZE_2M = 49'h20_0000;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_KCLR,
      WR_ENTRY,
      WR_LINK,
      WR_LEAF,
      WR_ZERO,
      WR_CLONE
   } wr_op_type;

   typedef struct packed {
      logic       load;
      logic       walk_start;
      logic       take;
      logic       cnt_inc;
      logic       desc_ptr;
      logic       desc_new;
      logic       step;
      logic       rd_kroot_cnt;
      logic       finish;
      logic       fin_found;
      logic [1:0] fin_status;
      wr_op_type  wr;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] lvl;
      logic       present;
      logic       ps;
      logic       ptr_ok;
      logic       can_take;
      logic       big;
      logic       last_step;
      logic       root_bad;
      logic       wraps;
      logic       size_zero;
      logic       cnt_last;
   } stat_type;

endpackage

// File: design/ptmw_ram.sv
// ----------------------------------------------------------------------------
// Page table map and walk: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptmw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ptmw_ctrl.sv
// ----------------------------------------------------------------------------
// Page table map and walk: controller
// Sequences clearing, table walks, allocation sweeps and clone copies.
// ----------------------------------------------------------------------------
module ptmw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ptmw_pkg::stat_type stat,
   output ptmw_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_MEVAL,
      ST_ZERO,
      ST_LINK,
      ST_NEXT,
      ST_TEVAL,
      ST_CREAD,
      ST_CWRITE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr      = ptmw_pkg::WR_KCLR;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (stat.req_type)
               ptmw_pkg::REQ_MAP: begin
                  if (stat.root_bad) begin
                     cmd.finish     = 1'b1;
                     cmd.fin_status = ptmw_pkg::STATUS_OUTSIDE;
                     state_in       = ST_IDLE;
                  end else if (stat.wraps || stat.size_zero) begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = ST_READ;
                  end
               end
               ptmw_pkg::REQ_TRANSLATE: begin
                  cmd.walk_start = 1'b1;
                  state_in       = ST_READ;
               end
               ptmw_pkg::REQ_CLONE: begin
                  if (stat.can_take) begin
                     cmd.take = 1'b1;
                     state_in = ST_CREAD;
                  end else begin
                     cmd.finish     = 1'b1;
                     cmd.fin_status = ptmw_pkg::STATUS_EXHAUSTED;
                     state_in       = ST_IDLE;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            state_in = (stat.req_type == ptmw_pkg::REQ_TRANSLATE) ? ST_TEVAL : ST_MEVAL;
         end
         ST_MEVAL: begin
            if (stat.present) begin
               cmd.wr = ptmw_pkg::WR_ENTRY;
               if (stat.ptr_ok) begin
                  cmd.desc_ptr = 1'b1;
                  state_in     = ST_NEXT;
               end else begin
                  cmd.finish     = 1'b1;
                  cmd.fin_status = ptmw_pkg::STATUS_OUTSIDE;
                  state_in       = ST_IDLE;
               end
            end else if (stat.can_take) begin
               cmd.take = 1'b1;
               state_in = ST_ZERO;
            end else begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ptmw_pkg::STATUS_EXHAUSTED;
               state_in       = ST_IDLE;
            end
         end
         ST_ZERO: begin
            cmd.wr      = ptmw_pkg::WR_ZERO;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.wr       = ptmw_pkg::WR_LINK;
            cmd.desc_new = 1'b1;
            state_in     = ST_NEXT;
         end
         ST_NEXT: begin
            if ((stat.lvl == 2'd0) || ((stat.lvl == 2'd1) && stat.big)) begin
               cmd.wr = ptmw_pkg::WR_LEAF;
               if (stat.last_step) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_TEVAL: begin
            if (!stat.present) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if ((stat.lvl == 2'd0) || ((stat.lvl == 2'd1) && stat.ps)) begin
               cmd.finish    = 1'b1;
               cmd.fin_found = 1'b1;
               state_in      = ST_IDLE;
            end else if (stat.ptr_ok) begin
               cmd.desc_ptr = 1'b1;
               state_in     = ST_READ;
            end else begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ptmw_pkg::STATUS_OUTSIDE;
               state_in       = ST_IDLE;
            end
         end
         ST_CREAD: begin
            cmd.rd_kroot_cnt = 1'b1;
            state_in         = ST_CWRITE;
         end
         ST_CWRITE: begin
            cmd.wr      = ptmw_pkg::WR_CLONE;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_CREAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/ptmw_dpath.sv
// ----------------------------------------------------------------------------
// Page table map and walk: datapath
// Request registers, pool bookkeeping, table memories and result registers.
// ----------------------------------------------------------------------------
module ptmw_dpath #(
   parameter int POOL_TABLES = ptmw_pkg::POOL_TABLES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [51:0]        csr_data,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_root_index,
   input  logic [47:0]        req_virt_addr,
   input  logic [63:0]        req_phys_addr_in,
   input  logic [48:0]        req_map_size,
   input  logic [63:0]        req_map_flags,
   input  ptmw_pkg::cmd_type  cmd,
   output ptmw_pkg::stat_type stat,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [63:0]        rsp_phys_out,
   output logic               rsp_found,
   output logic [6:0]         rsp_new_root_index
);

   localparam int IW     = $clog2(POOL_TABLES + 1);
   localparam int SW     = $clog2(POOL_TABLES);
   localparam int PAW    = SW + 9;
   localparam int PDEPTH = POOL_TABLES * 512;

   logic [51:0]   base_ff;
   logic [6:0]    pages_ff;
   logic [IW-1:0] used_ff, child_ff, tbl_ff;
   logic [1:0]    type_ff, lvl_ff;
   logic [6:0]    root_ff;
   logic [47:0]   va_ff;
   logic [63:0]   pa_ff, flags_ff;
   logic [48:0]   rem_ff;
   logic [8:0]    cnt_ff;
   logic          rsp_valid_ff, rsp_found_ff;
   logic [1:0]    rsp_status_ff;
   logic [63:0]   rsp_phys_ff;
   logic [6:0]    rsp_root_ff;

   logic [63:0]   kr_rdata, pl_rdata, ent, ent_fl, leaf_val, wval, tphys, slot_addr;
   logic [8:0]    idx;
   logic [39:0]   slot_off, slot_sum;
   logic [IW-1:0] ptr_id, root_id;
   logic [SW-1:0] child_slot, tbl_slot;
   logic [48:0]   step;
   logic [64:0]   end_sum;
   logic          tbl_wr, is_kernel, clone_ok;
   logic          kr_we, pl_we;
   logic [8:0]    kr_waddr, kr_raddr;
   logic [PAW-1:0] pl_waddr, pl_raddr;

   always_comb begin
      case (lvl_ff)
         2'd3:    idx = va_ff[47:39];
         2'd2:    idx = va_ff[38:30];
         2'd1:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign is_kernel  = (tbl_ff == '0);
   assign ent        = is_kernel ? kr_rdata : pl_rdata;
   assign ent_fl     = ent | (flags_ff & (ptmw_pkg::ENT_RW | ptmw_pkg::ENT_USER));
   assign slot_off   = ent[51:12] - base_ff[51:12];
   assign ptr_id     = IW'(slot_off) + IW'(1);
   assign root_id    = IW'(root_ff);
   assign child_slot = SW'(child_ff - IW'(1));
   assign tbl_slot   = SW'(tbl_ff - IW'(1));
   assign slot_sum   = base_ff[51:12] + 40'(child_slot);
   assign slot_addr  = {12'b0, slot_sum, 12'b0};
   assign step       = stat.big ? ptmw_pkg::SIZE_2M : ptmw_pkg::SIZE_4K;
   assign end_sum    = {1'b0, pa_ff} + 65'(rem_ff);
   assign leaf_val   = stat.big ? (pa_ff | flags_ff | ptmw_pkg::ENT_PS | ptmw_pkg::ENT_PRESENT)
                                : (pa_ff | (flags_ff & ~ptmw_pkg::ENT_PS) | ptmw_pkg::ENT_PRESENT);
   assign tphys      = (lvl_ff == 2'd1) ? {12'b0, ent[51:21], va_ff[20:0]}
                                        : {12'b0, ent[51:12], va_ff[11:0]};
   assign clone_ok   = (type_ff == ptmw_pkg::REQ_CLONE) &&
                       (cmd.fin_status == ptmw_pkg::STATUS_OK);

   always_comb begin
      stat.req_type  = type_ff;
      stat.lvl       = lvl_ff;
      stat.present   = ent[0];
      stat.ps        = ent[7];
      stat.ptr_ok    = (slot_off < 40'(used_ff));
      stat.can_take  = (16'(used_ff) < 16'(pages_ff)) && (16'(used_ff) < 16'(POOL_TABLES));
      stat.big       = (pa_ff[20:0] == '0) && (va_ff[20:0] == '0) &&
                       (rem_ff >= ptmw_pkg::SIZE_2M);
      stat.last_step = (rem_ff <= step);
      stat.root_bad  = (root_ff != '0) && (16'(root_ff) > 16'(used_ff));
      stat.wraps     = end_sum[64];
      stat.size_zero = (rem_ff == '0);
      stat.cnt_last  = (cnt_ff == 9'h1FF);
   end

   assign tbl_wr = (cmd.wr == ptmw_pkg::WR_ENTRY) || (cmd.wr == ptmw_pkg::WR_LINK) ||
                   (cmd.wr == ptmw_pkg::WR_LEAF);

   always_comb begin
      case (cmd.wr)
         ptmw_pkg::WR_ENTRY: wval = ent_fl;
         ptmw_pkg::WR_LINK:  wval = slot_addr | ptmw_pkg::ENT_PRESENT |
                                    (flags_ff & (ptmw_pkg::ENT_RW | ptmw_pkg::ENT_USER));
         ptmw_pkg::WR_LEAF:  wval = leaf_val;
         ptmw_pkg::WR_CLONE: wval = kr_rdata[0] ? kr_rdata : 64'h0;
         default:            wval = 64'h0;
      endcase
   end

   assign kr_we    = (cmd.wr == ptmw_pkg::WR_KCLR) || (tbl_wr && is_kernel);
   assign kr_waddr = (cmd.wr == ptmw_pkg::WR_KCLR) ? cnt_ff : idx;
   assign kr_raddr = cmd.rd_kroot_cnt ? cnt_ff : idx;
   assign pl_we    = (cmd.wr == ptmw_pkg::WR_ZERO) || (cmd.wr == ptmw_pkg::WR_CLONE) ||
                     (tbl_wr && !is_kernel);
   assign pl_waddr = ((cmd.wr == ptmw_pkg::WR_ZERO) || (cmd.wr == ptmw_pkg::WR_CLONE))
                     ? {child_slot, cnt_ff} : {tbl_slot, idx};
   assign pl_raddr = {tbl_slot, idx};

   ptmw_ram #(.WIDTH(64), .DEPTH(512)) u_kroot (
      .clock   (clock),
      .wr_en   (kr_we),
      .wr_addr (kr_waddr),
      .wr_data (wval),
      .rd_addr (kr_raddr),
      .rd_data (kr_rdata)
   );

   ptmw_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_pool (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_waddr),
      .wr_data (wval),
      .rd_addr (pl_raddr),
      .rd_data (pl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         pages_ff     <= '0;
         used_ff      <= '0;
         child_ff     <= '0;
         tbl_ff       <= '0;
         lvl_ff       <= '0;
         type_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ptmw_pkg::CSR_POOL_BASE:  base_ff  <= csr_data;
               default:                  pages_ff <= csr_data[6:0];
            endcase
         end
         if (cmd.load) begin
            type_ff <= req_type;
         end
         if (cmd.walk_start) begin
            tbl_ff <= (type_ff == ptmw_pkg::REQ_MAP) ? root_id : '0;
            lvl_ff <= 2'd3;
         end else if (cmd.desc_ptr) begin
            tbl_ff <= ptr_id;
            lvl_ff <= lvl_ff - 2'd1;
         end else if (cmd.desc_new) begin
            tbl_ff <= child_ff;
            lvl_ff <= lvl_ff - 2'd1;
         end else if (cmd.step) begin
            tbl_ff <= root_id;
            lvl_ff <= 2'd3;
         end
         if (cmd.take) begin
            used_ff  <= used_ff + IW'(1);
            child_ff <= used_ff + IW'(1);
            cnt_ff   <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 9'd1;
         end
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         root_ff  <= req_root_index;
         va_ff    <= req_virt_addr;
         pa_ff    <= req_phys_addr_in;
         rem_ff   <= req_map_size;
         flags_ff <= req_map_flags;
      end else if (cmd.step) begin
         rem_ff <= rem_ff - step;
         va_ff  <= va_ff + 48'(step);
         pa_ff  <= pa_ff + 64'(step);
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.fin_status;
         rsp_found_ff  <= cmd.fin_found;
         rsp_phys_ff   <= cmd.fin_found ? tphys : (clone_ok ? slot_addr : 64'h0);
         rsp_root_ff   <= clone_ok ? 7'(child_ff) : 7'd0;
      end
   end

   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_phys_out       = rsp_phys_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_new_root_index = rsp_root_ff;

endmodule

// File: design/page_table_map_and_walk_top.sv
// ----------------------------------------------------------------------------
// Page table map and walk: top level
// Keeps a kernel root table and a pool of four-level x86-64 page tables;
// serves map, translate and clone requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows,
// shown for a single cycle with rsp_valid, and the receiver cannot stall it.
// After reset the block clears all 512 entries of the kernel root table and
// holds busy high meanwhile. Every table access goes through one read of a
// table memory with registered read data, so each walk level is a read, then
// an evaluation of the entry, and for map a descend decision. Map walks once
// per 4 KiB or 2 MiB page and zeroes all 512 entries of every table it
// creates before linking it, and clone does a read and a write for each of the
// 512 root entries. The result appears in the cycle after the work ends.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`include "page_table_map_and_walk_top_defines.svh"

module page_table_map_and_walk_top #(
   parameter int POOL_TABLES = ptmw_pkg::POOL_TABLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_root_index,
   input  logic [47:0] req_virt_addr,
   input  logic [63:0] req_phys_addr_in,
   input  logic [48:0] req_map_size,
   input  logic [63:0] req_map_flags,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_phys_out,
   output logic        rsp_found,
   output logic [6:0]  rsp_new_root_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [51:0] csr_data
);

   ptmw_pkg::cmd_type  cmd;
   ptmw_pkg::stat_type stat;
   logic               start_ok;

   assign start_ok = start && !busy;

   ptmw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ptmw_dpath #(.POOL_TABLES(POOL_TABLES)) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid && csr_ready),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_type           (req_type),
      .req_root_index     (req_root_index),
      .req_virt_addr      (req_virt_addr),
      .req_phys_addr_in   (req_phys_addr_in),
      .req_map_size       (req_map_size),
      .req_map_flags      (req_map_flags),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_phys_out       (rsp_phys_out),
      .rsp_found          (rsp_found),
      .rsp_new_root_index (rsp_new_root_index)
   );

   `PTMW_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `PTMW_ASSERT_NEXT(a_start_busy, start_ok, busy)
   `PTMW_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found, rsp_status == ptmw_pkg::STATUS_OK)
   `PTMW_ASSERT_NOW(a_finish_busy, cmd.finish, busy)

endmodule
